// ===== rtl/afrpz_pkg.sv =====
package afrpz_pkg;

  // sample and result field widths
  localparam int SAMPLE_BITS = 16;
  localparam int LEVEL_W     = 16;
  localparam int COUNT_W     = 10;
  localparam int RATE_OUT_W  = 16;
  localparam int FRAME_NUM_W = 16;
  localparam int CFG_W       = 11;

  // packed result word: rms, peak, count, rate, frame number, zero fill
  localparam int OUT_FIELDS_W = 2 * LEVEL_W + COUNT_W + RATE_OUT_W + FRAME_NUM_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // square of one sample
  localparam int SQ_W = 2 * SAMPLE_BITS;

  // frame length after reset
  localparam logic [CFG_W-1:0] FRAME_LENGTH_RESET = CFG_W'(320);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_LAST,
    ST_DIVM,
    ST_SQRT,
    ST_DIVR,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/audio_frame_rms_peak_zcr.sv =====
// frame level meter: rms, peak and zero-crossing rate of signed q1.15 audio
//
// in_*  : one sample per word, tdata[15:0] signed two's complement
// cfg_* : frame length in samples (2..MAX_FRAME used, smaller acts as 2,
//         larger acts as MAX_FRAME), write only while the block is idle
// out_* : one result word at the end of each frame
//
// each sample is accepted, then squared and used to update the frame
// statistics, so in_tready is low in the cycle after each accepted word.
// the last sample of a frame starts the frame-end sequence on one shared
// subtract unit: mean of squares by restoring division, square root of the
// full-width mean, crossing rate by a second division, then the result is
// handed to the output register and out_tvalid rises. a result waits in
// the output register while the next frame's samples are taken; a stalled
// receiver holds off only the next frame end. reset clears the accumulators,
// the frame number and sets the frame length back to 320.
module audio_frame_rms_peak_zcr #(
  parameter int MAX_FRAME = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // sample input
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [15:0]                        in_tdata,   // [15:0] sample
  // frame length register
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [afrpz_pkg::CFG_W-1:0]        cfg_data,
  // results
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] rms_level, [31:16] peak_level, [41:32] crossing_count,
  // [57:42] crossing_rate, [73:58] frame_number, [79:74] zero
  output logic [afrpz_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int SB     = afrpz_pkg::SAMPLE_BITS;
  localparam int SQ_W   = afrpz_pkg::SQ_W;
  localparam int CNT_W  = $clog2(MAX_FRAME + 1);
  localparam int SUM_W  = 2 * SB - 1 + $clog2(MAX_FRAME);
  // mean of squares, large enough for a frame cut short by a length change
  localparam int MEAN_W = SUM_W - 1;
  // first trial bit of the root, highest even position of the mean
  localparam int ROOT_TOP = 2 * ((MEAN_W - 1) / 2);
  localparam int RATE_W = CNT_W + 16;
  localparam int CW     = $clog2(SUM_W + 1);
  localparam int PAD_W  = afrpz_pkg::OUT_DATA_W - afrpz_pkg::OUT_FIELDS_W;

  // control and model state
  afrpz_pkg::state_t              state_r, state_nxt;
  logic [afrpz_pkg::CFG_W-1:0]    frame_length_r, frame_length_nxt;
  logic [CNT_W-1:0]               seen_r, seen_nxt;
  logic [SUM_W-1:0]               sum_r, sum_nxt;
  logic [SB-1:0]                  peak_r, peak_nxt;
  logic                           prior_neg_r, prior_neg_nxt;
  logic [CNT_W-1:0]               cross_r, cross_nxt;
  logic [afrpz_pkg::FRAME_NUM_W-1:0] fcnt_r, fcnt_nxt;
  logic                           pend_r, pend_nxt;
  logic                           out_valid_r, out_valid_nxt;

  // working registers
  logic [SB-1:0]                  mag_r, mag_nxt;
  logic                           neg_r, neg_nxt;
  logic [SQ_W-1:0]                sq_r, sq_nxt;
  logic [CNT_W-1:0]               n_r, n_nxt;
  logic [SUM_W-1:0]               div_r, div_nxt;
  logic [CNT_W-1:0]               rem_r, rem_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic [MEAN_W-1:0]              v_r, v_nxt;
  logic [MEAN_W-1:0]              root_r, root_nxt;
  logic [MEAN_W-1:0]              bit_r, bit_nxt;
  logic [afrpz_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // combinational helpers
  logic [CNT_W-1:0]               n_eff;
  logic [CNT_W-1:0]               seen_inc;
  logic [SB-1:0]                  in_mag;
  logic [CNT_W:0]                 rem_sh;
  logic [MEAN_W-1:0]              sub_a, sub_b;
  logic [MEAN_W:0]                diff;
  logic                           ge;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // effective frame length, clamped into 2..MAX_FRAME
  always_comb begin
    priority if (frame_length_r < afrpz_pkg::CFG_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (32'(frame_length_r) > 32'(MAX_FRAME)) begin
      n_eff = CNT_W'(MAX_FRAME);
    end else begin
      n_eff = CNT_W'(frame_length_r);
    end
  end

  // magnitude of the incoming sample, most negative value maps to 2^(SB-1)
  assign in_mag   = in_tdata[SB-1] ? (~in_tdata + SB'(1)) : in_tdata;
  assign seen_inc = seen_r + CNT_W'(1);

  // shared compare-and-subtract unit
  assign rem_sh = {rem_r, div_r[SUM_W-1]};
  always_comb begin
    if (state_r == afrpz_pkg::ST_SQRT) begin
      sub_a = v_r;
      sub_b = root_r | bit_r;
    end else begin
      sub_a = MEAN_W'(rem_sh);
      sub_b = MEAN_W'(n_r);
    end
  end
  assign diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge   = ~diff[MEAN_W];

  // sequencer: next state and datapath control
  always_comb begin
    state_nxt        = state_r;
    frame_length_nxt = frame_length_r;
    seen_nxt         = seen_r;
    sum_nxt          = sum_r;
    peak_nxt         = peak_r;
    prior_neg_nxt    = prior_neg_r;
    cross_nxt        = cross_r;
    fcnt_nxt         = fcnt_r;
    pend_nxt         = pend_r;
    out_valid_nxt    = out_valid_r;
    mag_nxt          = mag_r;
    neg_nxt          = neg_r;
    sq_nxt           = sq_r;
    n_nxt            = n_r;
    div_nxt          = div_r;
    rem_nxt          = rem_r;
    cnt_nxt          = cnt_r;
    v_nxt            = v_r;
    root_nxt         = root_r;
    bit_nxt          = bit_r;
    out_data_nxt     = out_data_r;
    in_tready        = 1'b0;

    // register write
    if (cfg_valid) begin
      frame_length_nxt = cfg_data;
    end

    // result word taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      afrpz_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        // fold the previous square into the sum
        if (pend_r) begin
          sum_nxt  = sum_r + SUM_W'(sq_r);
          pend_nxt = 1'b0;
        end
        if (in_tvalid) begin
          mag_nxt   = in_mag;
          neg_nxt   = in_tdata[SB-1];
          state_nxt = afrpz_pkg::ST_ACC;
        end
      end

      afrpz_pkg::ST_ACC: begin
        sq_nxt   = SQ_W'(mag_r) * SQ_W'(mag_r);
        pend_nxt = 1'b1;
        if (mag_r > peak_r) begin
          peak_nxt = mag_r;
        end
        if (seen_r != '0 && neg_r != prior_neg_r) begin
          cross_nxt = cross_r + CNT_W'(1);
        end
        prior_neg_nxt = neg_r;
        if (seen_inc >= n_eff) begin
          n_nxt     = n_eff;
          state_nxt = afrpz_pkg::ST_LAST;
        end else begin
          seen_nxt  = seen_inc;
          state_nxt = afrpz_pkg::ST_IDLE;
        end
      end

      afrpz_pkg::ST_LAST: begin
        // complete sum goes straight into the divider
        div_nxt   = sum_r + SUM_W'(sq_r);
        sum_nxt   = '0;
        pend_nxt  = 1'b0;
        rem_nxt   = '0;
        cnt_nxt   = CW'(SUM_W);
        state_nxt = afrpz_pkg::ST_DIVM;
      end

      afrpz_pkg::ST_DIVM: begin
        // one quotient bit of sum / n per cycle
        div_nxt = {div_r[SUM_W-2:0], ge};
        rem_nxt = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          v_nxt     = div_nxt[MEAN_W-1:0];
          root_nxt  = '0;
          bit_nxt   = MEAN_W'(1) << ROOT_TOP;
          state_nxt = afrpz_pkg::ST_SQRT;
        end
      end

      afrpz_pkg::ST_SQRT: begin
        // one root bit per cycle
        if (ge) begin
          v_nxt    = diff[MEAN_W-1:0];
          root_nxt = (root_r >> 1) | bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          div_nxt   = SUM_W'({cross_r, 16'h0000}) << (SUM_W - RATE_W);
          rem_nxt   = '0;
          cnt_nxt   = CW'(RATE_W);
          state_nxt = afrpz_pkg::ST_DIVR;
        end
      end

      afrpz_pkg::ST_DIVR: begin
        // crossing count * 65536 / n
        div_nxt = {div_r[SUM_W-2:0], ge};
        rem_nxt = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = afrpz_pkg::ST_DONE;
        end
      end

      afrpz_pkg::ST_DONE: begin
        // hand over once the output register is free
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {{PAD_W{1'b0}}, fcnt_r, div_r[15:0],
                           afrpz_pkg::COUNT_W'(cross_r), peak_r, root_r[15:0]};
          out_valid_nxt = 1'b1;
          fcnt_nxt      = fcnt_r + afrpz_pkg::FRAME_NUM_W'(1);
          seen_nxt      = '0;
          peak_nxt      = '0;
          prior_neg_nxt = 1'b0;
          cross_nxt     = '0;
          state_nxt     = afrpz_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = afrpz_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= afrpz_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= afrpz_pkg::FRAME_LENGTH_RESET;
      seen_r         <= '0;
      sum_r          <= '0;
      peak_r         <= '0;
      prior_neg_r    <= 1'b0;
      cross_r        <= '0;
      fcnt_r         <= '0;
      pend_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      frame_length_r <= frame_length_nxt;
      seen_r         <= seen_nxt;
      sum_r          <= sum_nxt;
      peak_r         <= peak_nxt;
      prior_neg_r    <= prior_neg_nxt;
      cross_r        <= cross_nxt;
      fcnt_r         <= fcnt_nxt;
      pend_r         <= pend_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    sq_r       <= sq_nxt;
    n_r        <= n_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    v_r        <= v_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/afrpz_chk.sv =====
module afrpz_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [afrpz_pkg::OUT_DATA_W-1:0] out_tdata
);

  // frame number the next result word should carry
  logic [15:0] exp_frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_frame_r <= '0;
    end else if (out_tvalid && out_tready) begin
      exp_frame_r <= exp_frame_r + 16'd1;
    end
  end

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // no result straight out of reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // samples are never accepted back to back
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("sample accepted on back-to-back cycles");

  // frames are numbered in order, none skipped
  a_frame_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[73:58] == exp_frame_r)
    else $error("frame number out of sequence");

  // no crossings means zero rate, peak stays in range
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[31:16] <= 16'd32768)
      && ((out_tdata[41:32] != 10'd0) || (out_tdata[57:42] == 16'd0)))
    else $error("result fields inconsistent");

endmodule

bind audio_frame_rms_peak_zcr afrpz_chk u_afrpz_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
